>>> hdl/ord_pkg.sv
// Package for the overwriting ring deque: storage sizes, action codes and
// the packed command and result beats. No dependencies.
package ord_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;

  typedef struct packed {
    logic [2:0]            action;
    logic [DATA_WIDTH-1:0] push_value;
    logic [PTR_W-1:0]      read_index;
  } cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  index_error;
    logic [CNT_W-1:0]      element_count;
    logic                  is_full;
    logic                  is_empty;
  } res_t;

endpackage

>>> hdl/overwriting_ring_deque.sv
// Overwriting ring deque: top level with slot storage, pointers and result register.
// Depends on ord_pkg.
//
// One action per beat: push front/back, pop front/back, or read at an index
// counted from the front. Each accepted command gives exactly one result beat,
// registered on acceptance; a command can be taken every cycle,
// including while a finished result waits, as long as res_ready frees the
// result register. A push into a full buffer overwrites the element at the
// opposite end; popping an empty buffer changes nothing. Writing the capacity
// (0 reads as 1, above 16 reads as 16) clears the buffer in the same cycle;
// there is no clearing pass, and slots are never read before they are written.
module overwriting_ring_deque (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ord_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  ord_pkg::cmd_t              cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ord_pkg::res_t              res
);
  import ord_pkg::*;

  logic [DATA_WIDTH-1:0] slot_store [DEPTH];

  logic [CNT_W-1:0] capacity;
  logic [PTR_W-1:0] front_slot, front_slot_next;
  logic [PTR_W-1:0] back_next_slot, back_next_slot_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;

  logic             cmd_accept, cfg_accept, full;
  logic [PTR_W-1:0] top_slot, front_inc, front_dec, back_inc, back_dec;
  logic [CNT_W-1:0] front_plus, back_plus, read_sum;
  logic [PTR_W-1:0] wr_slot, rd_slot;
  logic             wr_en, rd_err, rd_hit;
  logic [CNT_W-1:0] cap_clamped;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign cmd_ready  = !res_valid || res_ready;
  assign cmd_accept = cmd_valid && cmd_ready;

  assign full     = stored_count >= capacity;
  assign top_slot = PTR_W'(capacity - 1'b1);

  // wrap within the slots in use, not the whole store
  assign front_plus = {1'b0, front_slot} + 1'b1;
  assign back_plus  = {1'b0, back_next_slot} + 1'b1;
  assign front_inc  = (front_plus >= capacity) ? '0 : front_plus[PTR_W-1:0];
  assign back_inc   = (back_plus >= capacity) ? '0 : back_plus[PTR_W-1:0];
  assign front_dec  = (front_slot == '0) ? top_slot : front_slot - 1'b1;
  assign back_dec   = (back_next_slot == '0) ? top_slot : back_next_slot - 1'b1;

  // index < count <= capacity, so one subtract brings it back into range
  assign read_sum = {1'b0, front_slot} + {1'b0, cmd.read_index};
  assign rd_slot  = (read_sum >= capacity) ? PTR_W'(read_sum - capacity)
                                           : read_sum[PTR_W-1:0];

  always_comb begin
    front_slot_next     = front_slot;
    back_next_slot_next = back_next_slot;
    stored_count_next   = stored_count;
    wr_en               = 1'b0;
    wr_slot             = back_next_slot;
    rd_err              = 1'b0;
    rd_hit              = 1'b0;
    unique case (cmd.action)
      ACT_PUSH_FRONT: begin
        wr_en           = 1'b1;
        wr_slot         = front_dec;
        front_slot_next = front_dec;
        if (!full) begin
          stored_count_next = stored_count + 1'b1;
        end else begin
          back_next_slot_next = front_dec;
        end
      end
      ACT_PUSH_BACK: begin
        wr_en               = 1'b1;
        wr_slot             = back_next_slot;
        back_next_slot_next = back_inc;
        if (!full) begin
          stored_count_next = stored_count + 1'b1;
        end else begin
          front_slot_next = back_inc;
        end
      end
      ACT_POP_FRONT: begin
        if (stored_count != '0) begin
          stored_count_next = stored_count - 1'b1;
          front_slot_next   = front_inc;
          if (stored_count == CNT_W'(1)) begin
            front_slot_next     = '0;
            back_next_slot_next = '0;
          end
        end
      end
      ACT_POP_BACK: begin
        if (stored_count != '0) begin
          stored_count_next   = stored_count - 1'b1;
          back_next_slot_next = back_dec;
          if (stored_count == CNT_W'(1)) begin
            front_slot_next     = '0;
            back_next_slot_next = '0;
          end
        end
      end
      ACT_READ: begin
        rd_err = {1'b0, cmd.read_index} >= stored_count;
        rd_hit = !rd_err;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (cfg_data > CNT_W'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CNT_W'(DEPTH);
      front_slot     <= '0;
      back_next_slot <= '0;
      stored_count   <= '0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_accept) begin
        capacity       <= cap_clamped;
        front_slot     <= '0;
        back_next_slot <= '0;
        stored_count   <= '0;
      end else if (cmd_accept) begin
        front_slot     <= front_slot_next;
        back_next_slot <= back_next_slot_next;
        stored_count   <= stored_count_next;
      end
      if (cmd_accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // storage and result payload, no reset
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      if (wr_en) begin
        slot_store[wr_slot] <= cmd.push_value;
      end
      res.read_data     <= rd_hit ? slot_store[rd_slot] : '0;
      res.index_error   <= rd_err;
      res.element_count <= stored_count_next;
      res.is_full       <= stored_count_next == capacity;
      res.is_empty      <= stored_count_next == '0;
    end
  end

endmodule

>>> hdl/ord_checker.sv
// Port-level checks for the overwriting ring deque, bound to the top level.
// Depends on ord_pkg and overwriting_ring_deque.
module ord_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [ord_pkg::CNT_W-1:0] cfg_data,
  input logic                      cmd_valid,
  input logic                      cmd_ready,
  input ord_pkg::cmd_t             cmd,
  input logic                      res_valid,
  input logic                      res_ready,
  input ord_pkg::res_t             res
);
  import ord_pkg::*;

  // no result beat straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // commands are only held off by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> (res_valid && !res_ready))
    else $error("command stalled without a waiting result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("stalled result beat changed");

  // a push always leaves something stored
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && !cfg_valid &&
     (cmd.action == ACT_PUSH_FRONT || cmd.action == ACT_PUSH_BACK))
    |=> (res_valid && !res.is_empty && res.element_count != '0))
    else $error("push reported an empty buffer");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.index_error) |-> (res.read_data == '0))
    else $error("failed read returned data");

endmodule

bind overwriting_ring_deque ord_checker u_ord_checker (.*);

>>> tb/sv/overwriting_ring_deque_tb.sv
// Self-checking testbench for overwriting_ring_deque: drives action beats and capacity
// writes, models the deque in a small class and checks every result beat against it.
// Depends on ord_pkg and the overwriting_ring_deque RTL.
module overwriting_ring_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ord_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int ITEMS_PER_PH = 190;
  localparam int NUM_PHASES   = 10;

  class deque_scoreboard;
    logic [DATA_WIDTH-1:0] slots [DEPTH];
    logic [CNT_W-1:0]      cap;
    logic [PTR_W-1:0]      head;
    logic [PTR_W-1:0]      tail;
    logic [CNT_W-1:0]      count;
    res_t                  pending_results [$];
    int                    mismatches;
    int                    checked;

    function new();
      foreach (slots[i]) slots[i] = '0;
      cap        = CNT_W'(DEPTH);
      mismatches = 0;
      checked    = 0;
      empty_out();
    endfunction

    function void empty_out();
      head  = '0;
      tail  = '0;
      count = '0;
    endfunction

    function void set_capacity(logic [CNT_W-1:0] v);
      if (v == 0) cap = CNT_W'(1);
      else if (int'(v) > DEPTH) cap = CNT_W'(DEPTH);
      else cap = v;
      empty_out();
    endfunction

    function logic [PTR_W-1:0] step_up(logic [PTR_W-1:0] s);
      return (int'(s) + 1 >= int'(cap)) ? '0 : PTR_W'(int'(s) + 1);
    endfunction

    // wraps to the top slot in use, not the top of storage
    function logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] s);
      return (s == 0) ? PTR_W'(int'(cap) - 1) : PTR_W'(int'(s) - 1);
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      logic full;
      int   pos;
      r    = '0;
      full = (count >= cap);
      case (c.action)
        ACT_PUSH_FRONT: begin
          head        = step_down(head);
          slots[head] = c.push_value;
          if (!full) count = count + 1'b1;
          else tail = head;
        end
        ACT_PUSH_BACK: begin
          slots[tail] = c.push_value;
          tail        = step_up(tail);
          if (!full) count = count + 1'b1;
          else head = tail;
        end
        ACT_POP_FRONT: begin
          if (count != 0) begin
            head  = step_up(head);
            count = count - 1'b1;
            if (count == 0) empty_out();
          end
        end
        ACT_POP_BACK: begin
          if (count != 0) begin
            tail  = step_down(tail);
            count = count - 1'b1;
            if (count == 0) empty_out();
          end
        end
        ACT_READ: begin
          if (int'(c.read_index) < int'(count)) begin
            pos = int'(head) + int'(c.read_index);
            if (pos >= int'(cap)) pos = pos - int'(cap);
            r.read_data = slots[pos];
          end else begin
            r.index_error = 1'b1;
          end
        end
        default: ;
      endcase
      r.element_count = count;
      r.is_full       = (count == cap);
      r.is_empty      = (count == 0);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (a !== e) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        mismatches++;
      end
    endfunction

    function void check_result(res_t a);
      res_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, a);
        mismatches++;
        return;
      end
      e = pending_results[0];
      pending_results.delete(0);
      checked++;
      compare_field("read_data", e.read_data, a.read_data);
      compare_field("index_error", 32'(e.index_error), 32'(a.index_error));
      compare_field("element_count", 32'(e.element_count), 32'(a.element_count));
      compare_field("is_full", 32'(e.is_full), 32'(a.is_full));
      compare_field("is_empty", 32'(e.is_empty), 32'(a.is_empty));
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_t             cmd       = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  res_t             res;

  deque_scoreboard sb = new();
  int idle_cycles  = 0;
  int burst_left   = 0;
  int cmds_sent    = 0;
  int cap_writes   = 0;
  int stall_left   = 0;
  int stall_mode   = 0;
  int rx_tick      = 0;

  overwriting_ring_deque uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: switches between always ready, light, heavy and periodic stalls
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= ($urandom_range(0, 3) != 0);
      2:       res_ready <= ($urandom_range(0, 3) == 0);
      default: res_ready <= (rx_tick % 4 != 0);
    endcase
  end

  // result beats are checked before the command beat of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) sb.check_result(res);
      if (cmd_valid && cmd_ready) sb.note_command(cmd);
      if ((res_valid && res_ready) || (cmd_valid && cmd_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [2:0] act, logic [DATA_WIDTH-1:0] v,
                                    logic [PTR_W-1:0] idx);
    cmd_t c;
    c.action     = act;
    c.push_value = v;
    c.read_index = idx;
    return c;
  endfunction

  // bias 0 fills and overwrites, 1 drains, 2 reads, 3 mixed
  function automatic cmd_t random_cmd(int bias, int cnt);
    cmd_t c;
    int   roll;
    int   push_pct;
    int   pop_pct;
    c.push_value = $urandom;
    roll = $urandom_range(0, 15);
    if (roll == 0) c.push_value = '0;
    else if (roll == 1) c.push_value = '1;
    c.read_index = PTR_W'($urandom_range(0, 15));
    case (bias)
      0:       begin push_pct = 70; pop_pct = 10; end
      1:       begin push_pct = 20; pop_pct = 60; end
      2:       begin push_pct = 30; pop_pct = 15; end
      default: begin push_pct = 40; pop_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3)
      c.action = 3'($urandom_range(5, 7));
    else if (roll < push_pct)
      c.action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    else if (roll < push_pct + pop_pct)
      c.action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    else
      c.action = ACT_READ;
    if (c.action == ACT_READ && cnt > 0 && $urandom_range(0, 3) != 0)
      c.read_index = PTR_W'($urandom_range(0, cnt - 1));
    return c;
  endfunction

  // call at a rising edge; returns at the edge that takes the beat
  task automatic send_cmd(input cmd_t c);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    burst_left--;
    cmds_sent++;
  endtask

  // wait for an edge first so the last command beat is noted before the count is looked at
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0 || res_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_capacity(v);
    cap_writes++;
  endtask

  initial begin
    logic [CNT_W-1:0] phase_cap [NUM_PHASES];
    int               bias;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty buffer at full depth: pops, bad read, unknown actions, then a short fill, reads and pops
    send_cmd(make_cmd(ACT_POP_FRONT, '0, '0));
    send_cmd(make_cmd(ACT_POP_BACK, '0, '0));
    send_cmd(make_cmd(ACT_READ, '0, '0));
    send_cmd(make_cmd(3'd5, '1, '1));
    send_cmd(make_cmd(3'd6, '0, '1));
    send_cmd(make_cmd(3'd7, '1, '0));
    send_cmd(make_cmd(ACT_PUSH_BACK, '1, '0));
    send_cmd(make_cmd(ACT_PUSH_FRONT, '0, '1));
    send_cmd(make_cmd(ACT_READ, '0, 4'd0));
    send_cmd(make_cmd(ACT_READ, '1, 4'd1));
    send_cmd(make_cmd(ACT_READ, '0, 4'd15));
    send_cmd(make_cmd(ACT_POP_BACK, '0, '0));
    send_cmd(make_cmd(ACT_POP_FRONT, '0, '0));

    // zero is taken as a single slot: each push after the first overwrites
    write_capacity('0);
    send_cmd(make_cmd(ACT_PUSH_FRONT, 32'h0000_0001, '0));
    send_cmd(make_cmd(ACT_PUSH_BACK, 32'h0000_0002, '0));
    send_cmd(make_cmd(ACT_READ, '0, 4'd0));
    send_cmd(make_cmd(ACT_POP_BACK, '0, '0));

    // two slots: overwrite from each end, then wrap both pointers
    write_capacity(CNT_W'(2));
    send_cmd(make_cmd(ACT_PUSH_BACK, 32'hA5A5_A5A5, '0));
    send_cmd(make_cmd(ACT_PUSH_BACK, 32'h5A5A_5A5A, '0));
    send_cmd(make_cmd(ACT_PUSH_BACK, 32'hDEAD_BEEF, '0));
    send_cmd(make_cmd(ACT_PUSH_FRONT, 32'h1234_5678, '0));
    send_cmd(make_cmd(ACT_READ, '0, 4'd0));
    send_cmd(make_cmd(ACT_READ, '0, 4'd1));
    send_cmd(make_cmd(ACT_POP_FRONT, '0, '0));
    send_cmd(make_cmd(ACT_POP_FRONT, '0, '0));

    phase_cap = '{5'd31, 5'd1, 5'd17, 5'd4, 5'd16, 5'd0, 5'd7, 5'd0, 5'd2, 5'd0};
    foreach (phase_cap[p]) begin
      if (p == 5 || p == 7 || p == 9) phase_cap[p] = CNT_W'($urandom_range(0, 31));
      write_capacity(phase_cap[p]);
      bias = 0;
      for (int i = 0; i < ITEMS_PER_PH; i++) begin
        if (i % 30 == 0) bias = (i == 0) ? 0 : $urandom_range(0, 3);
        send_cmd(random_cmd(bias, int'(sb.count)));
      end
    end

    drain();
    $display("Sent %0d action beats over %0d capacity writes, checked %0d result beats.",
             cmds_sent, cap_writes, sb.checked);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
